// File: hw/rtl/buddy_allocator_unit_assert.svh
`ifndef BUDDY_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication under the block clock and reset.
`define BAL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator check failed");

// Next-cycle implication under the block clock and reset.
`define BAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator check failed");

`endif

// File: hw/rtl/bal_pkg.sv
package bal_pkg;

    localparam int MAX_ORDER   = 14;
    localparam int ORDER_COUNT = MAX_ORDER + 1;
    localparam int MIN_ORDER   = 2;
    localparam int UNIT_W      = MAX_ORDER - MIN_ORDER;
    localparam int UNITS       = 1 << UNIT_W;
    localparam int LINK_W      = UNIT_W + 1;
    localparam int ORD_W       = $clog2(ORDER_COUNT);
    localparam int HIDX_W      = $clog2(ORDER_COUNT);

    typedef logic [UNIT_W-1:0] unit_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [ORD_W-1:0]  ord_t;

    localparam link_t NO_NODE = link_t'(UNITS);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;
    localparam logic STAT_OK       = 1'b0;
    localparam logic STAT_NO_SPACE = 1'b1;

    typedef struct packed {
        logic  node_re;
        unit_t node_raddr;
        logic  nb_we;
        unit_t nb_waddr;
        unit_t nb_wdata;
        logic  nn_we;
        unit_t nn_waddr;
        link_t nn_wdata;
        logic  pool_re;
        unit_t pool_raddr;
        logic  pool_we;
        unit_t pool_waddr;
        unit_t pool_wdata;
        logic  bo_re;
        unit_t bo_raddr;
        logic  bo_we;
        unit_t bo_waddr;
        ord_t  bo_wdata;
    } mem_req_t;

    typedef struct packed {
        unit_t nb_rdata;
        link_t nn_rdata;
        unit_t pool_rdata;
        ord_t  bo_rdata;
    } mem_rsp_t;

    // Bit length of a 17-bit value.
    function automatic logic [4:0] bit_len(input logic [16:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 0; i < 17; i++)
        begin
            if (v[i])
            begin
                r = 5'(i + 1);
            end
        end
        return r;
    endfunction

    function automatic unit_t order_bit(input ord_t o);
        ord_t sh;
        sh = o - ord_t'(MIN_ORDER);
        return unit_t'(1) << sh;
    endfunction

endpackage

// File: hw/rtl/buddy_allocator_unit.sv
// Channel   | Ports                                   | Handshake
// request   | cmd, req_size, free_addr                | start high while busy low
// result    | data_addr, status                       | done, one cycle, no stall
// config    | heap_base_wdata                         | heap_base_we, any cycle when idle
//
// Allocate scans the free lists upward from the needed order, pops a node
// and splits down to that order, pushing each upper buddy. Free reads the
// block's order, then walks each order's list for its buddy and merges up
// while the buddy is found.
// The result strobe rises in the cycle busy falls; an oversize allocate is
// answered in the cycle after acceptance without raising busy.
// Reset clears the control state at once; there is no clearing pass.
module buddy_allocator_unit
    import bal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [15:0] req_size,
    input  logic [31:0] free_addr,
    input  logic        heap_base_we,
    input  logic [31:0] heap_base_wdata,
    output logic        done,
    output logic [31:0] data_addr,
    output logic        status
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_POP_RD, S_SPLIT, S_PUSH_RD, S_FIN,
        S_FORD, S_MERGE, S_WALK, S_WALK_RD, S_PUSHF
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] base_reg;
    link_t       list_head_reg[ORDER_COUNT];
    link_t       list_head_next[ORDER_COUNT];
    link_t       pool_top_reg, pool_top_next;
    link_t       wmark_reg, wmark_next;
    logic        nb0_init_reg, nb0_init_next;
    logic        nn0_init_reg, nn0_init_next;
    logic        bo0_init_reg, bo0_init_next;
    logic        is_free_reg, is_free_next;
    ord_t        ord_reg, ord_next;
    ord_t        h_reg, h_next;
    unit_t       unit_reg, unit_next;
    unit_t       blk_reg, blk_next;
    unit_t       node_reg, node_next;
    link_t       prev_reg, prev_next;
    link_t       cur_reg, cur_next;
    unit_t       tgt_reg, tgt_next;
    logic        byp_reg, byp_next;
    logic        done_reg, done_next;
    logic [31:0] addr_reg, addr_next;
    logic        status_reg, status_next;

    mem_req_t mreq;
    mem_rsp_t mrsp;

    bal_mem u_mem (
        .clk (clk),
        .req (mreq),
        .rsp (mrsp)
    );

    logic [4:0]  need_ord;
    logic [31:0] foff;
    ord_t        rd_ord;
    ord_t        hm1;
    unit_t       split_b;
    unit_t       take_n;
    unit_t       rd_blk;
    link_t       rd_nxt;
    unit_t       cur_u;

    assign need_ord = bit_len(17'(req_size) + 17'd3);
    assign foff     = free_addr - base_reg - 32'd4;
    assign hm1      = h_reg - ord_t'(1);
    assign split_b  = unit_reg ^ order_bit(hm1);
    assign take_n   = byp_reg ? pool_top_reg[UNIT_W-1:0] : mrsp.pool_rdata;
    assign cur_u    = cur_reg[UNIT_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        list_head_next = list_head_reg;
        pool_top_next = pool_top_reg;
        wmark_next    = wmark_reg;
        nb0_init_next = nb0_init_reg;
        nn0_init_next = nn0_init_reg;
        bo0_init_next = bo0_init_reg;
        is_free_next  = is_free_reg;
        ord_next      = ord_reg;
        h_next        = h_reg;
        unit_next     = unit_reg;
        blk_next      = blk_reg;
        node_next     = node_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        tgt_next      = tgt_reg;
        byp_next      = byp_reg;
        done_next     = 1'b0;
        addr_next     = addr_reg;
        status_next   = status_reg;
        mreq          = '0;
        rd_ord        = '0;
        rd_blk        = '0;
        rd_nxt        = NO_NODE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    is_free_next = (cmd == CMD_FREE);
                    if (cmd == CMD_ALLOC)
                    begin
                        if (need_ord > 5'(MAX_ORDER))
                        begin
                            done_next   = 1'b1;
                            addr_next   = '0;
                            status_next = STAT_NO_SPACE;
                        end
                        else
                        begin
                            ord_next   = ord_t'(need_ord);
                            h_next     = ord_t'(need_ord);
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        unit_next      = foff[UNIT_W+1:2];
                        mreq.bo_re     = 1'b1;
                        mreq.bo_raddr  = foff[UNIT_W+1:2];
                        state_next     = S_FORD;
                    end
                end
            end

            S_SCAN:
            begin
                if (list_head_reg[h_reg] != NO_NODE)
                begin
                    mreq.node_re    = 1'b1;
                    mreq.node_raddr = list_head_reg[h_reg][UNIT_W-1:0];
                    node_next       = list_head_reg[h_reg][UNIT_W-1:0];
                    state_next      = S_POP_RD;
                end
                else if (h_reg == ord_t'(MAX_ORDER))
                begin
                    done_next   = 1'b1;
                    addr_next   = '0;
                    status_next = STAT_NO_SPACE;
                    state_next  = S_IDLE;
                end
                else
                begin
                    h_next = h_reg + ord_t'(1);
                end
            end

            S_POP_RD:
            begin
                rd_nxt = (node_reg == '0 && nn0_init_reg) ? NO_NODE : mrsp.nn_rdata;
                rd_blk = (node_reg == '0 && nb0_init_reg) ? unit_t'(0) : mrsp.nb_rdata;
                list_head_next[h_reg] = rd_nxt;
                if (pool_top_reg != '0)
                begin
                    pool_top_next   = pool_top_reg - link_t'(1);
                    mreq.pool_we    = 1'b1;
                    mreq.pool_waddr = pool_top_next[UNIT_W-1:0];
                    mreq.pool_wdata = node_reg;
                    if (pool_top_reg > wmark_reg)
                    begin
                        wmark_next = pool_top_reg;
                    end
                end
                unit_next  = rd_blk;
                state_next = (h_reg > ord_reg) ? S_SPLIT : S_FIN;
            end

            S_SPLIT:
            begin
                h_next        = hm1;
                blk_next      = split_b;
                mreq.bo_we    = 1'b1;
                mreq.bo_waddr = split_b;
                mreq.bo_wdata = hm1;
                if (split_b == '0)
                begin
                    bo0_init_next = 1'b0;
                end
                if (pool_top_reg < NO_NODE)
                begin
                    mreq.pool_re    = 1'b1;
                    mreq.pool_raddr = pool_top_reg[UNIT_W-1:0];
                    byp_next        = (pool_top_reg >= wmark_reg);
                    state_next      = S_PUSH_RD;
                end
                else
                begin
                    state_next = (hm1 > ord_reg) ? S_SPLIT : S_FIN;
                end
            end

            S_PUSH_RD:
            begin
                mreq.nb_we    = 1'b1;
                mreq.nb_waddr = take_n;
                mreq.nb_wdata = blk_reg;
                mreq.nn_we    = 1'b1;
                mreq.nn_waddr = take_n;
                mreq.nn_wdata = list_head_reg[h_reg];
                list_head_next[h_reg] = {1'b0, take_n};
                pool_top_next = pool_top_reg + link_t'(1);
                if (take_n == '0)
                begin
                    nb0_init_next = 1'b0;
                    nn0_init_next = 1'b0;
                end
                if (is_free_reg)
                begin
                    done_next   = 1'b1;
                    addr_next   = '0;
                    status_next = STAT_OK;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = (h_reg > ord_reg) ? S_SPLIT : S_FIN;
                end
            end

            S_FIN:
            begin
                mreq.bo_we    = 1'b1;
                mreq.bo_waddr = unit_reg;
                mreq.bo_wdata = ord_reg;
                if (unit_reg == '0)
                begin
                    bo0_init_next = 1'b0;
                end
                done_next   = 1'b1;
                addr_next   = base_reg + {{(30 - UNIT_W){1'b0}}, unit_reg, 2'b00} + 32'd4;
                status_next = STAT_OK;
                state_next  = S_IDLE;
            end

            S_FORD:
            begin
                rd_ord = (unit_reg == '0 && bo0_init_reg) ? ord_t'(MAX_ORDER) : mrsp.bo_rdata;
                if (rd_ord < ord_t'(MIN_ORDER))
                begin
                    rd_ord = ord_t'(MIN_ORDER);
                end
                if (rd_ord > ord_t'(MAX_ORDER))
                begin
                    rd_ord = ord_t'(MAX_ORDER);
                end
                h_next     = rd_ord;
                unit_next  = unit_reg & ~(order_bit(rd_ord) - unit_t'(1));
                state_next = S_MERGE;
            end

            S_MERGE:
            begin
                if (h_reg < ord_t'(MAX_ORDER))
                begin
                    tgt_next   = unit_reg ^ order_bit(h_reg);
                    cur_next   = list_head_reg[h_reg];
                    prev_next  = NO_NODE;
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = S_PUSHF;
                end
            end

            S_WALK:
            begin
                if (cur_reg == NO_NODE)
                begin
                    state_next = S_PUSHF;
                end
                else
                begin
                    mreq.node_re    = 1'b1;
                    mreq.node_raddr = cur_u;
                    state_next      = S_WALK_RD;
                end
            end

            S_WALK_RD:
            begin
                rd_nxt = (cur_u == '0 && nn0_init_reg) ? NO_NODE : mrsp.nn_rdata;
                rd_blk = (cur_u == '0 && nb0_init_reg) ? unit_t'(0) : mrsp.nb_rdata;
                if (rd_blk == tgt_reg)
                begin
                    if (prev_reg == NO_NODE)
                    begin
                        list_head_next[h_reg] = rd_nxt;
                    end
                    else
                    begin
                        mreq.nn_we    = 1'b1;
                        mreq.nn_waddr = prev_reg[UNIT_W-1:0];
                        mreq.nn_wdata = rd_nxt;
                        if (prev_reg[UNIT_W-1:0] == '0)
                        begin
                            nn0_init_next = 1'b0;
                        end
                    end
                    if (pool_top_reg != '0)
                    begin
                        pool_top_next   = pool_top_reg - link_t'(1);
                        mreq.pool_we    = 1'b1;
                        mreq.pool_waddr = pool_top_next[UNIT_W-1:0];
                        mreq.pool_wdata = cur_u;
                        if (pool_top_reg > wmark_reg)
                        begin
                            wmark_next = pool_top_reg;
                        end
                    end
                    unit_next  = unit_reg & ~order_bit(h_reg);
                    h_next     = h_reg + ord_t'(1);
                    state_next = S_MERGE;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = rd_nxt;
                    state_next = S_WALK;
                end
            end

            S_PUSHF:
            begin
                mreq.bo_we    = 1'b1;
                mreq.bo_waddr = unit_reg;
                mreq.bo_wdata = h_reg;
                if (unit_reg == '0)
                begin
                    bo0_init_next = 1'b0;
                end
                blk_next = unit_reg;
                if (pool_top_reg < NO_NODE)
                begin
                    mreq.pool_re    = 1'b1;
                    mreq.pool_raddr = pool_top_reg[UNIT_W-1:0];
                    byp_next        = (pool_top_reg >= wmark_reg);
                    state_next      = S_PUSH_RD;
                end
                else
                begin
                    done_next   = 1'b1;
                    addr_next   = '0;
                    status_next = STAT_OK;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            base_reg  <= '0;
            for (int i = 0; i < ORDER_COUNT; i++)
            begin
                list_head_reg[i] <= (i == MAX_ORDER) ? link_t'(0) : NO_NODE;
            end
            pool_top_reg <= link_t'(1);
            wmark_reg    <= '0;
            nb0_init_reg <= 1'b1;
            nn0_init_reg <= 1'b1;
            bo0_init_reg <= 1'b1;
            done_reg     <= 1'b0;
            addr_reg     <= '0;
            status_reg   <= STAT_OK;
        end
        else
        begin
            state_reg <= state_next;
            if (heap_base_we)
            begin
                base_reg <= heap_base_wdata;
            end
            list_head_reg <= list_head_next;
            pool_top_reg  <= pool_top_next;
            wmark_reg     <= wmark_next;
            nb0_init_reg  <= nb0_init_next;
            nn0_init_reg  <= nn0_init_next;
            bo0_init_reg  <= bo0_init_next;
            done_reg      <= done_next;
            addr_reg      <= addr_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_free_reg <= is_free_next;
        ord_reg     <= ord_next;
        h_reg       <= h_next;
        unit_reg    <= unit_next;
        blk_reg     <= blk_next;
        node_reg    <= node_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        tgt_reg     <= tgt_next;
        byp_reg     <= byp_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign data_addr = addr_reg;
    assign status    = status_reg;

endmodule

// File: hw/rtl/bal_mem.sv
module bal_mem
    import bal_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output mem_rsp_t rsp
);

    unit_t node_block_mem [UNITS];
    link_t node_next_mem  [UNITS];
    unit_t node_pool_mem  [UNITS];
    ord_t  block_order_mem[UNITS];

    always_ff @(posedge clk)
    begin
        if (req.nb_we)
        begin
            node_block_mem[req.nb_waddr] <= req.nb_wdata;
        end
        if (req.nn_we)
        begin
            node_next_mem[req.nn_waddr] <= req.nn_wdata;
        end
        if (req.pool_we)
        begin
            node_pool_mem[req.pool_waddr] <= req.pool_wdata;
        end
        if (req.bo_we)
        begin
            block_order_mem[req.bo_waddr] <= req.bo_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.node_re)
        begin
            rsp.nb_rdata <= node_block_mem[req.node_raddr];
            rsp.nn_rdata <= node_next_mem[req.node_raddr];
        end
        if (req.pool_re)
        begin
            rsp.pool_rdata <= node_pool_mem[req.pool_raddr];
        end
        if (req.bo_re)
        begin
            rsp.bo_rdata <= block_order_mem[req.bo_raddr];
        end
    end

endmodule

// File: hw/rtl/bal_checker.sv
`include "buddy_allocator_unit_assert.svh"

module bal_checker
    import bal_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] data_addr,
    input logic        status
);

    // An accepted request either keeps the block working or is answered at once.
    `BAL_ASSERT_NEXT(a_accept_busy, start && !busy, busy || done)
    // The result shows only once the block has gone idle.
    `BAL_ASSERT_NOW(a_done_idle, done, !busy)
    // An idle block with no request produces no result in the next cycle.
    `BAL_ASSERT_NEXT(a_no_stray_done, !busy && !start, !done)
    // A failed allocate reports no address.
    `BAL_ASSERT_NOW(a_fail_zero, done && status == STAT_NO_SPACE, data_addr == '0)

endmodule

bind buddy_allocator_unit bal_checker u_bal_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .data_addr (data_addr),
    .status    (status)
);

// File: test/buddy_allocator_unit_checker.sv
module buddy_allocator_unit_checker
    import bal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        cmd,
    input  logic [15:0] req_size,
    input  logic [31:0] free_addr,
    input  logic        heap_base_we,
    input  logic [31:0] heap_base_wdata,
    input  logic        done,
    input  logic [31:0] data_addr,
    input  logic        status,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] addr;
        logic        stat;
    } alloc_outcome_t;

    // Shadow copy of the free lists, node pool and per-unit order records.
    unit_t       blk_of_node[UNITS];
    link_t       next_of_node[UNITS];
    unit_t       spare_node[UNITS];
    int unsigned spare_top;
    link_t       list_top[ORDER_COUNT];
    int unsigned unit_order[UNITS];
    logic [31:0] heap_origin;

    alloc_outcome_t pending_results[$];

    assign outstanding = pending_results.size();

    function automatic bit grab_node(output unit_t n);
        if (spare_top >= UNITS)
            return 0;
        n = spare_node[spare_top];
        spare_top++;
        return 1;
    endfunction

    function automatic void return_node(input unit_t n);
        if (spare_top > 0)
        begin
            spare_top--;
            spare_node[spare_top] = n;
        end
    endfunction

    function automatic void list_push(input int unsigned ord, input unit_t u);
        unit_t n;
        if (ord >= ORDER_COUNT || !grab_node(n))
            return;
        blk_of_node[n]  = u;
        next_of_node[n] = list_top[ord];
        list_top[ord]   = link_t'(n);
    endfunction

    function automatic bit list_pop(input int unsigned ord, output unit_t u);
        link_t n;
        n = list_top[ord];
        if (n >= NO_NODE)
            return 0;
        list_top[ord] = next_of_node[unit_t'(n)];
        return_node(unit_t'(n));
        u = blk_of_node[unit_t'(n)];
        return 1;
    endfunction

    function automatic bit list_unlink(input int unsigned ord, input unit_t u);
        link_t prev;
        link_t cur;
        prev = NO_NODE;
        cur  = list_top[ord];
        for (int steps = 0; steps < UNITS && cur < NO_NODE; steps++)
        begin
            if (blk_of_node[unit_t'(cur)] == u)
            begin
                if (prev == NO_NODE)
                    list_top[ord] = next_of_node[unit_t'(cur)];
                else
                    next_of_node[unit_t'(prev)] = next_of_node[unit_t'(cur)];
                return_node(unit_t'(cur));
                return 1;
            end
            prev = cur;
            cur  = next_of_node[unit_t'(cur)];
        end
        return 0;
    endfunction

    function automatic alloc_outcome_t predict_request(input logic c, input logic [15:0] sz,
                                                       input logic [31:0] fa);
        alloc_outcome_t r;
        logic [16:0]    v;
        int unsigned    ord;
        int unsigned    h;
        unit_t          u;
        unit_t          mate;
        r.addr = '0;
        r.stat = STAT_OK;
        u      = '0;
        if (c == CMD_ALLOC)
        begin
            v   = 17'(sz) + 17'd3;
            ord = 0;
            for (int i = 0; i < 17; i++)
                if (v[i])
                    ord = i + 1;
            if (ord > MAX_ORDER)
            begin
                r.stat = STAT_NO_SPACE;
                return r;
            end
            for (h = ord; h <= MAX_ORDER; h++)
                if (list_pop(h, u))
                    break;
            if (h > MAX_ORDER)
            begin
                r.stat = STAT_NO_SPACE;
                return r;
            end
            while (h > ord)
            begin
                h--;
                mate = u ^ unit_t'(1 << (h - MIN_ORDER));
                unit_order[mate] = h;
                list_push(h, mate);
            end
            unit_order[u] = ord;
            r.addr = heap_origin + (32'(u) << 2) + 32'd4;
            return r;
        end
        u   = unit_t'((fa - heap_origin - 32'd4) >> 2);
        ord = unit_order[u];
        if (ord < MIN_ORDER)
            ord = MIN_ORDER;
        if (ord > MAX_ORDER)
            ord = MAX_ORDER;
        u &= ~unit_t'((1 << (ord - MIN_ORDER)) - 1);
        while (ord < MAX_ORDER && list_unlink(ord, u ^ unit_t'(1 << (ord - MIN_ORDER))))
        begin
            u &= ~unit_t'(1 << (ord - MIN_ORDER));
            ord++;
        end
        unit_order[u] = ord;
        list_push(ord, u);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_outcome_t want;
        if (!rst_n)
        begin
            heap_origin = '0;
            for (int i = 0; i < ORDER_COUNT; i++)
                list_top[i] = NO_NODE;
            for (int i = 0; i < UNITS; i++)
            begin
                blk_of_node[i]  = '0;
                next_of_node[i] = '0;
                unit_order[i]   = 0;
                spare_node[i]   = unit_t'(i);
            end
            next_of_node[0]     = NO_NODE;
            list_top[MAX_ORDER] = '0;
            spare_top           = 1;
            unit_order[0]       = MAX_ORDER;
            mismatches          = 0;
            pending_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request outstanding: addr %h status %0d",
                                 $realtime, data_addr, status);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (data_addr !== want.addr || status !== want.stat)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: expected addr %h status %0d, got addr %h status %0d",
                                     $realtime, want.addr, want.stat, data_addr, status);
                    end
                end
            end
            if (heap_base_we)
                heap_origin = heap_base_wdata;
            if (start && !busy)
                pending_results.push_back(predict_request(cmd, req_size, free_addr));
        end
    end

endmodule

// File: test/buddy_allocator_unit_tb.sv
module buddy_allocator_unit_tb;
    import bal_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cmd = CMD_ALLOC;
    logic [15:0] req_size = '0;
    logic [31:0] free_addr = '0;
    logic        heap_base_we = 1'b0;
    logic [31:0] heap_base_wdata = '0;
    logic        done;
    logic [31:0] data_addr;
    logic        status;
    int          mismatches;
    int          outstanding;

    logic [31:0] cur_base = '0;
    logic        issued_cmds[$];
    unit_t       live_units[$];
    unit_t       ever_units[$];
    int          cycles = 0;
    int          n_alloc_ok = 0;
    int          n_alloc_fail = 0;
    int          n_free = 0;
    bit          allow_gaps = 1;

    always #5 clk = ~clk;

    buddy_allocator_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .req_size(req_size), .free_addr(free_addr), .heap_base_we(heap_base_we),
        .heap_base_wdata(heap_base_wdata), .done(done), .data_addr(data_addr),
        .status(status)
    );

    buddy_allocator_unit_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .req_size(req_size), .free_addr(free_addr), .heap_base_we(heap_base_we),
        .heap_base_wdata(heap_base_wdata), .done(done), .data_addr(data_addr),
        .status(status), .mismatches(mismatches), .outstanding(outstanding)
    );

    // Track which blocks the allocator handed out so frees only name written headers.
    always @(posedge clk)
    begin
        logic  kind;
        unit_t u;
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (done && issued_cmds.size() > 0)
        begin
            kind = issued_cmds.pop_front();
            if (kind == CMD_FREE)
                n_free++;
            else if (status == STAT_NO_SPACE)
                n_alloc_fail++;
            else
            begin
                n_alloc_ok++;
                u = unit_t'((data_addr - cur_base - 32'd4) >> 2);
                live_units.push_back(u);
                if (ever_units.size() < 512)
                    ever_units.push_back(u);
            end
        end
    end

    task automatic issue(input logic c, input logic [15:0] sz, input logic [31:0] fa);
        if (allow_gaps && $urandom_range(0, 5) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        cmd       = c;
        req_size  = sz;
        free_addr = fa;
        start     = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        issued_cmds.push_back(c);
        @(negedge clk);
        start = 1'b0;
    endtask

    function automatic logic [31:0] addr_of(input unit_t u);
        return cur_base + 32'd4 + (32'(u) << 2);
    endfunction

    task automatic alloc_req(input logic [15:0] sz);
        issue(CMD_ALLOC, sz, $urandom);
    endtask

    task automatic free_live(input int idx);
        unit_t u;
        u = live_units[idx];
        live_units.delete(idx);
        issue(CMD_FREE, 16'($urandom), addr_of(u));
    endtask

    // Free a block whose header was written before, through stray address bits.
    task automatic free_stray();
        unit_t       u;
        logic [31:0] off;
        u   = ever_units[$urandom_range(0, ever_units.size() - 1)];
        off = (32'(u) << 2) | 32'($urandom_range(0, 3)) | ($urandom << MAX_ORDER);
        issue(CMD_FREE, 16'($urandom), cur_base + 32'd4 + off);
    endtask

    task automatic settle();
        while (outstanding != 0 || busy || issued_cmds.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_base(input logic [31:0] b);
        heap_base_we    = 1'b1;
        heap_base_wdata = b;
        @(negedge clk);
        heap_base_we = 1'b0;
        cur_base     = b;
    endtask

    task automatic random_phase(input int count);
        int          pick;
        logic [15:0] sz;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (live_units.size() == 0 || pick < 52)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    sz = 16'($urandom_range(0, 60));
                else if (pick < 92)
                    sz = 16'($urandom_range(61, 2000));
                else if (pick < 97)
                    sz = 16'($urandom_range(2001, 16380));
                else
                    sz = 16'($urandom);
                alloc_req(sz);
            end
            else if (pick < 95 || ever_units.size() == 0)
                free_live($urandom_range(0, live_units.size() - 1));
            else
                free_stray();
        end
    endtask

    initial
    begin
        logic [31:0] bases[4];
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero size, whole heap, oversize, full size field, double free.
        alloc_req(16'd0);
        alloc_req(16'd16380);
        alloc_req(16'd16381);
        alloc_req(16'hFFFF);
        alloc_req(16'd1);
        alloc_req(16'd13);
        alloc_req(16'd100);
        settle();
        free_live(0);
        free_live(0);
        settle();
        issue(CMD_FREE, 16'hFFFF, addr_of(ever_units[0]));
        alloc_req(16'd16380);
        settle();
        while (live_units.size() > 0)
            free_live(live_units.size() - 1);
        alloc_req(16'd16380);
        alloc_req(16'd4);
        settle();
        free_live(0);
        settle();
        free_stray();
        alloc_req(16'd8188);
        settle();

        bases[0] = 32'hFFFF_FFFC;
        bases[1] = 32'hFFFF_FFFF;
        bases[2] = $urandom;
        bases[3] = 32'h0000_0000;
        for (int p = 0; p < 4; p++)
        begin
            settle();
            set_base(bases[p]);
            if (p == 3)
                allow_gaps = 0;
            random_phase(460);
        end
        settle();

        $display("Covered %0d allocations, %0d failed allocations and %0d frees over four heap bases.",
                 n_alloc_ok, n_alloc_fail, n_free);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/bal_pkg.sv
hw/rtl/bal_mem.sv
hw/rtl/buddy_allocator_unit.sv
hw/rtl/bal_checker.sv
test/buddy_allocator_unit_checker.sv
test/buddy_allocator_unit_tb.sv
